// ===== rtl/crcfb_pkg.sv =====
package crcfb_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 64;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SYNC_RESET    = 8'd165;
    localparam logic [3:0] VERSION_RESET = 4'd1;

    // Extra bytes around the payload: sync, type/version, length, two CRC bytes
    localparam int FRAME_OVERHEAD = 5;

    // Register select, taken from paddr[2]
    localparam logic REG_SYNC    = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_FRAME = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;
    localparam logic [1:0] ERR_OPEN     = 2'd3;

    localparam int BURST_MAX = 5;
    localparam int CNT_W     = 3;

    // All result beats caused by one input item
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      close;
        logic [1:0]                err;
    } t_burst;

    // CRC16-CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crcfb_core.sv =====
module crcfb_core
    import crcfb_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_sync_value,
    input  logic [3:0] i_version_value,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  logic [3:0] i_packet_type,
    input  logic [7:0] i_payload_length,
    input  logic [7:0] i_payload_byte,
    input  logic       i_burst_ready,
    output logic       o_burst_valid,
    output t_burst     o_burst
);

    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_tv;
    logic [7:0]  r_in_len;
    logic [7:0]  r_in_byte;
    logic [15:0] r_in_base;

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_rem, n_rem;
    logic        r_open, n_open;

    logic        advance;
    logic        load;
    logic [7:0]  tv;
    logic [15:0] crc_src;
    logic [7:0]  crc_data;
    logic [15:0] crc_new;
    logic [7:0]  rem_dec;
    logic        too_long;
    t_burst      burst;

    assign advance       = r_in_valid && i_burst_ready;
    assign o_stall       = r_in_valid && !i_burst_ready;
    assign load          = i_valid && !o_stall;
    assign o_burst_valid = r_in_valid;
    assign o_burst       = burst;

    assign tv = {i_packet_type, i_version_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // CRC over the type/version byte is folded in ahead, so the second stage
    // only has one byte of CRC to do.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_op   <= i_opcode;
            r_in_tv   <= tv;
            r_in_len  <= i_payload_length;
            r_in_byte <= i_payload_byte;
            r_in_base <= crc_byte(CRC_INIT, tv);
        end
    end

    assign crc_src  = (r_in_op == OP_START) ? r_in_base : r_crc;
    assign crc_data = (r_in_op == OP_START) ? r_in_len : r_in_byte;
    assign crc_new  = crc_byte(crc_src, crc_data);
    assign rem_dec  = r_rem - 8'd1;
    assign too_long = (int'(r_in_len) + FRAME_OVERHEAD) > MAX_FRAME_BYTES;

    always_comb begin
        burst       = '0;
        burst.cnt   = CNT_W'(1);
        burst.close = 1'b0;
        burst.err   = ERR_NONE;
        n_crc       = r_crc;
        n_rem       = r_rem;
        n_open      = r_open;
        if (r_in_op == OP_START) begin
            if (r_open) begin
                burst.err = ERR_OPEN;
            end else if (too_long) begin
                burst.err = ERR_TOO_LONG;
            end else begin
                burst.bytes[0] = i_sync_value;
                burst.bytes[1] = r_in_tv;
                burst.bytes[2] = r_in_len;
                if (r_in_len == 8'd0) begin
                    burst.bytes[3] = crc_new[7:0];
                    burst.bytes[4] = crc_new[15:8];
                    burst.cnt      = CNT_W'(5);
                    burst.close    = 1'b1;
                end else begin
                    burst.cnt = CNT_W'(3);
                    n_crc     = crc_new;
                    n_rem     = r_in_len;
                    n_open    = 1'b1;
                end
            end
        end else begin
            if (!r_open) begin
                burst.err = ERR_NO_FRAME;
            end else begin
                burst.bytes[0] = r_in_byte;
                if (rem_dec == 8'd0) begin
                    burst.bytes[1] = crc_new[7:0];
                    burst.bytes[2] = crc_new[15:8];
                    burst.cnt      = CNT_W'(3);
                    burst.close    = 1'b1;
                    n_crc          = CRC_INIT;
                    n_rem          = 8'd0;
                    n_open         = 1'b0;
                end else begin
                    n_crc = crc_new;
                    n_rem = rem_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_rem  <= 8'd0;
            r_open <= 1'b0;
        end else if (advance) begin
            r_crc  <= n_crc;
            r_rem  <= n_rem;
            r_open <= n_open;
        end
    end

endmodule

// ===== rtl/crcfb_ser.sv =====
module crcfb_ser
    import crcfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_burst_valid,
    input  t_burst     i_burst,
    output logic       o_burst_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_frame,
    output logic [1:0] o_error_code
);

    logic             r_valid;
    t_burst           r_burst;
    logic [CNT_W-1:0] r_idx;
    logic             last;
    logic             load;

    assign last          = (CNT_W'(r_idx + CNT_W'(1)) == r_burst.cnt);
    assign o_burst_ready = !r_valid || (last && !i_stall);
    assign load          = i_burst_valid && o_burst_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && !i_stall) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= CNT_W'(r_idx + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_burst <= i_burst;
        end
    end

    assign o_valid        = r_valid;
    assign o_frame_byte   = r_burst.bytes[r_idx];
    assign o_last_of_run  = last;
    assign o_end_of_frame = r_burst.close && last;
    assign o_error_code   = r_burst.err;

endmodule

// ===== rtl/crc16_frame_builder.sv =====
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_opcode, i_packet_type, i_payload_length,
//                                         i_payload_byte
// output    out        o_valid / i_stall  o_frame_byte, o_last_of_run, o_end_of_frame,
//                                         o_error_code
// config    in         APB psel/penable   paddr, pwdata, prdata, pready
//
// An accepted beat is held in the input register; while it is held its result burst is built,
// and the burst is loaded into the output register once that register can take it.
// Each item gives 1, 3 or 5 result beats, one beat a cycle at the output register while
// i_stall is low; a new item is taken while the last beat goes out.
// Reset is synchronous: no frame open, CRC at 0xFFFF, registers at their defaults.
// i_stall holds the current beat; backpressure reaches o_stall via the input register.
module crc16_frame_builder
    import crcfb_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [3:0]  i_packet_type,
    input  logic [7:0]  i_payload_length,
    input  logic [7:0]  i_payload_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_of_run,
    output logic        o_end_of_frame,
    output logic [1:0]  o_error_code
);

    logic [7:0] r_sync_value;
    logic [3:0] r_version_value;
    logic       cfg_wr;
    logic       burst_valid;
    logic       burst_ready;
    t_burst     burst;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value    <= SYNC_RESET;
            r_version_value <= VERSION_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SYNC:    r_sync_value    <= pwdata[7:0];
                REG_VERSION: r_version_value <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SYNC:    prdata = {24'd0, r_sync_value};
            REG_VERSION: prdata = {28'd0, r_version_value};
            default:     prdata = '0;
        endcase
    end

    crcfb_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sync_value     (r_sync_value),
        .i_version_value  (r_version_value),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_packet_type    (i_packet_type),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .i_burst_ready    (burst_ready),
        .o_burst_valid    (burst_valid),
        .o_burst          (burst)
    );

    crcfb_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_burst_valid  (burst_valid),
        .i_burst        (burst),
        .o_burst_ready  (burst_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_byte   (o_frame_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame),
        .o_error_code   (o_error_code)
    );

endmodule
